>>> hw/rtl/vkf_pkg.sv
// shared types, constants and helper functions of the vertical kalman filter
package vkf_pkg;

   localparam int COV_FRAC_DEF    = 18;
   localparam int HEIGHT_FRAC_DEF = 28;
   localparam int SPEED_FRAC_DEF  = 19;
   localparam int ACCEL_FRAC_DEF  = 10;
   localparam int MEAS_FRAC_DEF   = 8;
   localparam int STEP_SHIFT_DEF  = 9;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_HEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_BIAS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SPEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_BIAS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE   = 3'd6;

   localparam logic [30:0] NOISE_SPEED_RST = 31'd51;
   localparam logic [30:0] MEAS_NOISE_RST  = 31'd262144;

   typedef enum logic [1:0] {
      FUNC_PROPAGATE = 2'd0,
      FUNC_UPDATE    = 2'd1,
      FUNC_INIT      = 2'd2,
      FUNC_NONE      = 2'd3
   } func_type;

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       div_load;
      logic       div_step;
      logic       gain_load;
      logic       mul_lo;
      logic       mul_hi;
      logic       corr;
      logic       apply;
      logic       load_out;
      logic [1:0] gain_sel;
   } vkf_cmd_type;

   typedef struct packed {
      func_type func;
      logic     div_last;
      logic     out_free;
   } vkf_status_type;

   // right shift for amt >= 0, left shift otherwise
   function automatic logic [31:0] sshift32(logic [31:0] v, int amt);
      if (amt >= 0) begin
         if (amt > 31) return 32'($signed(v) >>> 31);
         return 32'($signed(v) >>> amt);
      end
      if (amt <= -32) return '0;
      return v << (-amt);
   endfunction

   function automatic logic [63:0] lshift_or_asr64(logic [63:0] v, int amt);
      if (amt >= 0) begin
         if (amt >= 64) return '0;
         return v << amt;
      end
      if (amt <= -64) return 64'($signed(v) >>> 63);
      return 64'($signed(v) >>> (-amt));
   endfunction

endpackage

>>> hw/rtl/vkf_ctrl.sv
// controller state machine of the vertical kalman filter
module vkf_ctrl import vkf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  vkf_status_type status,
   output vkf_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_EXEC    = 10'b0000000010,
      S_DIVLOAD = 10'b0000000100,
      S_DIV     = 10'b0000001000,
      S_GAIN    = 10'b0000010000,
      S_MULLO   = 10'b0000100000,
      S_MULHI   = 10'b0001000000,
      S_CORR    = 10'b0010000000,
      S_APPLY   = 10'b0100000000,
      S_OUT     = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.gain_sel = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            sel_in   = 2'd0;
            if (status.func == FUNC_UPDATE) state_in = S_DIVLOAD;
            else state_in = S_OUT;
         end
         S_DIVLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_GAIN;
         end
         S_GAIN: begin
            cmd.gain_load = 1'b1;
            state_in      = S_MULLO;
         end
         S_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MULHI;
         end
         S_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_CORR;
         end
         S_CORR: begin
            cmd.corr = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (sel_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_DIVLOAD;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

>>> hw/rtl/vkf_dp.sv
// datapath of the vertical kalman filter: state, covariance, divider, multiplier
module vkf_dp import vkf_pkg::*; #(
   parameter int COV_FRAC    = COV_FRAC_DEF,
   parameter int HEIGHT_FRAC = HEIGHT_FRAC_DEF,
   parameter int SPEED_FRAC  = SPEED_FRAC_DEF,
   parameter int ACCEL_FRAC  = ACCEL_FRAC_DEF,
   parameter int MEAS_FRAC   = MEAS_FRAC_DEF,
   parameter int STEP_SHIFT  = STEP_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vkf_cmd_type          cmd,
   output vkf_status_type       status,
   input  logic [1:0]           req_func,
   input  logic signed [31:0]   req_accel,
   input  logic signed [31:0]   req_height_meas,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [63:0]   rsp_height,
   output logic signed [31:0]   rsp_speed,
   output logic signed [31:0]   rsp_bias,
   output logic signed [31:0]   rsp_accel_unbiased
);

   localparam int NW = 32 + COV_FRAC;
   localparam int CW = $clog2(NW);
   localparam logic [31:0] GRAVITY_FX = 32'((64'd981 << ACCEL_FRAC) / 64'd100);
   localparam int H_SHIFT = STEP_SHIFT + SPEED_FRAC - HEIGHT_FRAC;
   localparam int S_SHIFT = STEP_SHIFT + ACCEL_FRAC - SPEED_FRAC;
   localparam int M_SHIFT = HEIGHT_FRAC - MEAS_FRAC;
   localparam logic [31:0] P_ONE = 32'(64'd1 << COV_FRAC);

   logic [31:0] init_height_ff, init_speed_ff, init_bias_ff;
   logic [30:0] noise_height_ff, noise_speed_ff, noise_bias_ff, meas_noise_ff;

   func_type    func_ff;
   logic [31:0] accel_ff, meas_ff;

   logic [63:0] est_height_ff;
   logic [31:0] est_speed_ff, est_bias_ff, last_accel_ff;
   logic [31:0] p_ff [9];
   logic [31:0] p_in [9];

   logic [63:0] y_ff;
   logic [31:0] s_ff;

   logic [NW-1:0] num_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   quo_ff, dmag_ff, k_ff;
   logic          neg_ff, dzero_ff;
   logic [CW-1:0] cnt_ff;

   logic [63:0] plo_ff, corr_ff;
   logic [31:0] phi_ff;

   logic        rsp_valid_ff;
   logic [63:0] out_height_ff;
   logic [31:0] out_speed_ff, out_bias_ff, out_accel_ff;

   logic [31:0]   la_in, t0, t1, t3, t4, num_src;
   logic [NW-1:0] nwide;
   logic [32:0]   rem_sh;
   logic          rem_ge;
   logic [31:0]   mul_b;
   logic [63:0]   mprod, prod;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_height_ff  <= '0;
         init_speed_ff   <= '0;
         init_bias_ff    <= '0;
         noise_height_ff <= '0;
         noise_speed_ff  <= NOISE_SPEED_RST;
         noise_bias_ff   <= '0;
         meas_noise_ff   <= MEAS_NOISE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INIT_HEIGHT:  init_height_ff  <= csr_wdata;
            CSR_INIT_SPEED:   init_speed_ff   <= csr_wdata;
            CSR_INIT_BIAS:    init_bias_ff    <= csr_wdata;
            CSR_NOISE_HEIGHT: noise_height_ff <= csr_wdata[30:0];
            CSR_NOISE_SPEED:  noise_speed_ff  <= csr_wdata[30:0];
            CSR_NOISE_BIAS:   noise_bias_ff   <= csr_wdata[30:0];
            CSR_MEAS_NOISE:   meas_noise_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         accel_ff <= req_accel;
         meas_ff  <= req_height_meas;
      end
   end

   // propagate
   assign la_in = accel_ff + GRAVITY_FX - est_bias_ff;
   assign t0 = p_ff[3] + p_ff[1] + 32'($signed(p_ff[4]) >>> STEP_SHIFT);
   assign t1 = p_ff[4] - p_ff[2] - 32'($signed(p_ff[5]) >>> STEP_SHIFT);
   assign t3 = (32'd0 - p_ff[6]) + p_ff[4] - 32'($signed(p_ff[7]) >>> STEP_SHIFT);
   assign t4 = (32'd0 - p_ff[7]) - p_ff[5] + 32'($signed(p_ff[8]) >>> STEP_SHIFT);

   always_comb begin
      p_in[0] = p_ff[0] + 32'($signed(t0) >>> STEP_SHIFT) + {1'b0, noise_height_ff};
      p_in[1] = p_ff[1] + 32'($signed(t1) >>> STEP_SHIFT);
      p_in[2] = p_ff[2] + 32'($signed(p_ff[5]) >>> STEP_SHIFT);
      p_in[3] = p_ff[3] + 32'($signed(t3) >>> STEP_SHIFT);
      p_in[4] = p_ff[4] + 32'($signed(t4) >>> STEP_SHIFT) + {1'b0, noise_speed_ff};
      p_in[5] = p_ff[5] - 32'($signed(p_ff[8]) >>> STEP_SHIFT);
      p_in[6] = p_ff[6] + 32'($signed(p_ff[7]) >>> STEP_SHIFT);
      p_in[7] = p_ff[7] - 32'($signed(p_ff[8]) >>> STEP_SHIFT);
      p_in[8] = p_ff[8] + {1'b0, noise_bias_ff};
   end

   // divider operands
   always_comb begin
      unique case (cmd.gain_sel)
         2'd0:    num_src = p_ff[0];
         2'd1:    num_src = p_ff[3];
         default: num_src = p_ff[6];
      endcase
   end
   assign nwide  = {num_src, {COV_FRAC{1'b0}}};
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign rem_ge = (rem_sh >= {1'b0, dmag_ff});

   // 32x32 multiplier, low 64 bits of k * y assembled over two passes
   assign mul_b = cmd.mul_hi ? y_ff[63:32] : y_ff[31:0];
   assign mprod = 64'(k_ff) * 64'(mul_b);
   assign prod  = plo_ff + {phi_ff - (k_ff[31] ? y_ff[31:0] : 32'd0), 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         est_height_ff <= '0;
         est_speed_ff  <= '0;
         est_bias_ff   <= '0;
         last_accel_ff <= '0;
         for (int i = 0; i < 9; i++) p_ff[i] <= (i == 0 || i == 4 || i == 8) ? P_ONE : '0;
      end else if (cmd.exec) begin
         unique case (func_ff)
            FUNC_PROPAGATE: begin
               last_accel_ff <= la_in;
               est_height_ff <= est_height_ff
                  + 64'($signed(sshift32(est_speed_ff, H_SHIFT)));
               est_speed_ff  <= est_speed_ff + sshift32(la_in, S_SHIFT);
               for (int i = 0; i < 9; i++) p_ff[i] <= p_in[i];
            end
            FUNC_INIT: begin
               est_height_ff <= {{32{init_height_ff[31]}}, init_height_ff};
               est_speed_ff  <= init_speed_ff;
               est_bias_ff   <= init_bias_ff;
               last_accel_ff <= '0;
               for (int i = 0; i < 9; i++)
                  p_ff[i] <= (i == 0 || i == 4 || i == 8) ? P_ONE : '0;
            end
            FUNC_UPDATE, FUNC_NONE: ;
         endcase
      end else if (cmd.apply) begin
         unique case (cmd.gain_sel)
            2'd0:    est_height_ff <= est_height_ff + corr_ff;
            2'd1:    est_speed_ff  <= est_speed_ff + corr_ff[31:0];
            default: est_bias_ff   <= est_bias_ff + corr_ff[31:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         y_ff <= lshift_or_asr64({{32{meas_ff[31]}}, meas_ff}, M_SHIFT) - est_height_ff;
         s_ff <= p_ff[0] + {1'b0, meas_noise_ff};
      end
      if (cmd.div_load) begin
         num_ff   <= nwide[NW-1] ? (NW'(0) - nwide) : nwide;
         rem_ff   <= '0;
         quo_ff   <= '0;
         dmag_ff  <= s_ff[31] ? (32'd0 - s_ff) : s_ff;
         neg_ff   <= num_src[31] ^ s_ff[31];
         dzero_ff <= (s_ff == 32'd0);
         cnt_ff   <= CW'(NW - 1);
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_ge ? 32'(rem_sh - {1'b0, dmag_ff}) : rem_sh[31:0];
         quo_ff <= {quo_ff[30:0], rem_ge};
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.gain_load) begin
         k_ff <= dzero_ff ? 32'd0 : (neg_ff ? (32'd0 - quo_ff) : quo_ff);
      end
      if (cmd.mul_lo) plo_ff <= mprod;
      if (cmd.mul_hi) phi_ff <= mprod[31:0];
      if (cmd.corr) corr_ff <= 64'($signed(prod) >>> COV_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_height_ff <= est_height_ff;
         out_speed_ff  <= est_speed_ff;
         out_bias_ff   <= est_bias_ff;
         out_accel_ff  <= last_accel_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.div_last = (cnt_ff == CW'(0));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_height         = out_height_ff;
   assign rsp_speed          = out_speed_ff;
   assign rsp_bias           = out_bias_ff;
   assign rsp_accel_unbiased = out_accel_ff;

endmodule

>>> hw/rtl/vertical_kalman_filter_unit.sv
// Three-state vertical Kalman filter (height, vertical speed, accelerometer bias).
// Request channel req_*: req_func selects propagate (req_accel), update
// (req_height_meas) or reinitialize; a request is taken when req_valid is high
// and req_stall is low. Every request yields one response on rsp_* with the
// state after the request; the receiver holds it off with rsp_stall.
// Configuration csr_*: register index and write data, taken when csr_valid and
// csr_ready are high; write only while no request is in flight.
// Propagate, reinitialize and the unused code skip the divider and go to the
// response register. An update runs the one-bit-per-cycle restoring divider
// once for each of the three gains, each gain followed by two passes through
// a 32x32 multiplier.
// One request is worked on at a time; the next is taken while the previous
// response still waits, and the block holds in its final cycle while rsp_stall
// keeps the response register full.
// Reset loads the register defaults, zero state and the unit covariance.
module vertical_kalman_filter_unit import vkf_pkg::*; #(
   parameter int COV_FRAC    = COV_FRAC_DEF,
   parameter int HEIGHT_FRAC = HEIGHT_FRAC_DEF,
   parameter int SPEED_FRAC  = SPEED_FRAC_DEF,
   parameter int ACCEL_FRAC  = ACCEL_FRAC_DEF,
   parameter int MEAS_FRAC   = MEAS_FRAC_DEF,
   parameter int STEP_SHIFT  = STEP_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic signed [31:0]   req_accel,
   input  logic signed [31:0]   req_height_meas,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [63:0]   rsp_height,
   output logic signed [31:0]   rsp_speed,
   output logic signed [31:0]   rsp_bias,
   output logic signed [31:0]   rsp_accel_unbiased,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   vkf_cmd_type    cmd;
   vkf_status_type status;

   vkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vkf_dp #(
      .COV_FRAC    (COV_FRAC),
      .HEIGHT_FRAC (HEIGHT_FRAC),
      .SPEED_FRAC  (SPEED_FRAC),
      .ACCEL_FRAC  (ACCEL_FRAC),
      .MEAS_FRAC   (MEAS_FRAC),
      .STEP_SHIFT  (STEP_SHIFT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_accel          (req_accel),
      .req_height_meas    (req_height_meas),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_height         (rsp_height),
      .rsp_speed          (rsp_speed),
      .rsp_bias           (rsp_bias),
      .rsp_accel_unbiased (rsp_accel_unbiased)
   );

endmodule

>>> test/testbench.sv
// self-checking testbench of the vertical kalman filter unit
`timescale 1ns / 100ps

module testbench;
   import vkf_pkg::*;

   localparam int COV_FRAC    = COV_FRAC_DEF;
   localparam int HEIGHT_FRAC = HEIGHT_FRAC_DEF;
   localparam int SPEED_FRAC  = SPEED_FRAC_DEF;
   localparam int ACCEL_FRAC  = ACCEL_FRAC_DEF;
   localparam int MEAS_FRAC   = MEAS_FRAC_DEF;
   localparam int STEP_SHIFT  = STEP_SHIFT_DEF;
   localparam logic [31:0] GRAVITY = 32'((64'd981 << ACCEL_FRAC) / 64'd100);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [63:0] height;
      logic [31:0] speed;
      logic [31:0] bias;
      logic [31:0] accel_unbiased;
   } estimate_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      func_type             func;
      logic [31:0]          accel;
      logic [31:0]          meas;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          wdata;
      bit                   has_exp;
      estimate_type         exp;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_func;
   logic signed [31:0]   req_accel;
   logic signed [31:0]   req_height_meas;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [63:0]   rsp_height;
   logic signed [31:0]   rsp_speed;
   logic signed [31:0]   rsp_bias;
   logic signed [31:0]   rsp_accel_unbiased;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   // filter model state and registers
   logic [31:0] reg_init_height, reg_init_speed, reg_init_bias;
   logic [31:0] reg_noise_height, reg_noise_speed, reg_noise_bias, reg_meas_noise;
   logic [63:0] m_height;
   logic [31:0] m_speed, m_bias, m_accel;
   logic [31:0] m_cov [9];

   estimate_type expected_estimates [$];
   stim_row_type stim_table [$];
   int        errors;
   int        mismatches;
   int        cycles;
   int        burst_left;
   int        func_count [4];
   int        zero_gain_updates;
   bit        hold_trigger;
   bit        hold_done;
   int        hold_cnt;
   int        stall_mode;

   vertical_kalman_filter_unit u_dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] asr32(logic [31:0] v, int s);
      if (s > 31) s = 31;
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] shift32(logic [31:0] v, int amt);
      if (amt >= 0) return asr32(v, amt);
      if (amt <= -32) return '0;
      return v << (-amt);
   endfunction

   function automatic logic [63:0] scale64(logic [63:0] v, int amt);
      if (amt >= 64) return '0;
      if (amt >= 0) return v << amt;
      if (amt <= -64) return 64'($signed(v) >>> 63);
      return 64'($signed(v) >>> (-amt));
   endfunction

   function automatic logic [63:0] sext(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] kalman_gain(logic [31:0] num, logic [31:0] s);
      logic signed [63:0] n;
      logic signed [63:0] d;
      d = $signed(sext(s));
      if (d == 0) return '0;
      n = $signed(sext(num)) <<< COV_FRAC;
      return 32'(n / d);
   endfunction

   function automatic logic [63:0] correction(logic [31:0] k, logic [63:0] y);
      logic [63:0] prod;
      prod = sext(k) * y;
      return 64'($signed(prod) >>> COV_FRAC);
   endfunction

   task automatic reload_filter();
      m_height = sext(reg_init_height);
      m_speed  = reg_init_speed;
      m_bias   = reg_init_bias;
      m_accel  = '0;
      foreach (m_cov[i]) m_cov[i] = '0;
      m_cov[0] = 32'd1 << COV_FRAC;
      m_cov[4] = 32'd1 << COV_FRAC;
      m_cov[8] = 32'd1 << COV_FRAC;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
         CSR_INIT_HEIGHT:  reg_init_height  = v;
         CSR_INIT_SPEED:   reg_init_speed   = v;
         CSR_INIT_BIAS:    reg_init_bias    = v;
         CSR_NOISE_HEIGHT: reg_noise_height = {1'b0, v[30:0]};
         CSR_NOISE_SPEED:  reg_noise_speed  = {1'b0, v[30:0]};
         CSR_NOISE_BIAS:   reg_noise_bias   = {1'b0, v[30:0]};
         CSR_MEAS_NOISE:   reg_meas_noise   = {1'b0, v[30:0]};
         default: ;
      endcase
   endtask

   task automatic filter_step(func_type f, logic [31:0] accel, logic [31:0] meas,
                              output estimate_type est);
      logic [31:0] p [9];
      logic [31:0] t, s, k1, k2, k3;
      logic [63:0] y;
      p = m_cov;
      case (f)
         FUNC_PROPAGATE: begin
            m_accel  = accel + GRAVITY - m_bias;
            m_height = m_height + sext(shift32(m_speed, STEP_SHIFT + SPEED_FRAC - HEIGHT_FRAC));
            m_speed  = m_speed + shift32(m_accel, STEP_SHIFT + ACCEL_FRAC - SPEED_FRAC);
            t = p[3] + p[1] + asr32(p[4], STEP_SHIFT);
            m_cov[0] = p[0] + asr32(t, STEP_SHIFT) + reg_noise_height;
            t = p[4] - p[2] - asr32(p[5], STEP_SHIFT);
            m_cov[1] = p[1] + asr32(t, STEP_SHIFT);
            m_cov[2] = p[2] + asr32(p[5], STEP_SHIFT);
            t = (32'd0 - p[6]) + p[4] - asr32(p[7], STEP_SHIFT);
            m_cov[3] = p[3] + asr32(t, STEP_SHIFT);
            t = (32'd0 - p[7]) - p[5] + asr32(p[8], STEP_SHIFT);
            m_cov[4] = p[4] + asr32(t, STEP_SHIFT) + reg_noise_speed;
            m_cov[5] = p[5] - asr32(p[8], STEP_SHIFT);
            m_cov[6] = p[6] + asr32(p[7], STEP_SHIFT);
            m_cov[7] = p[7] - asr32(p[8], STEP_SHIFT);
            m_cov[8] = p[8] + reg_noise_bias;
         end
         FUNC_UPDATE: begin
            y  = scale64(sext(meas), HEIGHT_FRAC - MEAS_FRAC) - m_height;
            s  = p[0] + reg_meas_noise;
            if (s == 0) zero_gain_updates++;
            k1 = kalman_gain(p[0], s);
            k2 = kalman_gain(p[3], s);
            k3 = kalman_gain(p[6], s);
            m_height = m_height + correction(k1, y);
            m_speed  = m_speed + 32'(correction(k2, y));
            m_bias   = m_bias + 32'(correction(k3, y));
         end
         FUNC_INIT: reload_filter();
         default: ;
      endcase
      est = '{m_height, m_speed, m_bias, m_accel};
   endtask

   task automatic send_request(func_type f, logic [31:0] accel, logic [31:0] meas,
                               bit has_exp, estimate_type exp);
      estimate_type est;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_func        = f;
      req_accel       = accel;
      req_height_meas = meas;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      filter_step(f, accel, meas, est);
      if (has_exp && est != exp) begin
         errors++;
         $display("table row disagrees with model: %h vs %h", exp, est);
      end
      expected_estimates.push_back(has_exp ? exp : est);
      func_count[f]++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      req_valid  = 1'b0;
      burst_left = 0;
      while (expected_estimates.size() != 0) @(negedge clock);
      csr_index = idx;
      csr_wdata = v;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      write_register(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_init_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return $urandom;
         default: return 32'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   function automatic logic [31:0] pick_noise_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return '0;
         2: return $urandom;
         default: return $urandom_range(0, 300000);
      endcase
   endfunction

   task automatic add_row(row_kind_type kind, func_type f, logic [31:0] a, logic [31:0] m,
                          bit has_exp, estimate_type exp);
      stim_row_type r;
      r.kind = kind; r.func = f; r.accel = a; r.meas = m;
      r.index = a[CSR_IDX_W-1:0]; r.wdata = m; r.has_exp = has_exp; r.exp = exp;
      stim_table.push_back(r);
   endtask

   // receiver stall pattern with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
         hold_cnt  = 0;
         hold_done = 1'b0;
         stall_mode = 0;
      end else if (hold_trigger && !hold_done) begin
         hold_done = 1'b1;
         hold_cnt  = HOLD_CYCLES;
         rsp_stall = 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall = 1'b1;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            default: rsp_stall = ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      estimate_type act;
      estimate_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         act = '{rsp_height, rsp_speed, rsp_bias, rsp_accel_unbiased};
         if (expected_estimates.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", act);
         end else begin
            exp = expected_estimates.pop_front();
            if (act != exp) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: height %h/%h speed %h/%h bias %h/%h accel %h/%h",
                           exp.height, act.height, exp.speed, act.speed,
                           exp.bias, act.bias, exp.accel_unbiased, act.accel_unbiased);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type r;
      estimate_type none;
      func_type  f;
      logic [31:0] a, m;
      int pick;
      errors = 0; mismatches = 0; cycles = 0; burst_left = 0;
      zero_gain_updates = 0; hold_trigger = 1'b0;
      foreach (func_count[i]) func_count[i] = 0;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0; req_func = FUNC_NONE; req_accel = '0; req_height_meas = '0;
      csr_valid = 1'b0; csr_index = CSR_INIT_HEIGHT; csr_wdata = '0;
      reg_init_height = '0; reg_init_speed = '0; reg_init_bias = '0;
      reg_noise_height = '0; reg_noise_speed = 32'(NOISE_SPEED_RST);
      reg_noise_bias = '0; reg_meas_noise = 32'(MEAS_NOISE_RST);
      reload_filter();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      add_row(ROW_REQ, FUNC_NONE, 0, 0, 1'b1, none);
      add_row(ROW_REQ, FUNC_INIT, 0, 0, 1'b1, none);
      add_row(ROW_REQ, FUNC_PROPAGATE, 0, 0, 1'b1, '{64'd0, GRAVITY, 32'd0, GRAVITY});
      add_row(ROW_REQ, FUNC_PROPAGATE, 32'h7fff_ffff, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_PROPAGATE, 32'h8000_0000, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 0, 32'h7fff_ffff, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 0, 32'h8000_0000, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 32'hffff_ffff, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_NONE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_INIT_HEIGHT), 32'h7fff_ffff, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_INIT_SPEED), 32'h8000_0000, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_INIT_BIAS), 32'hffff_ffff, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_UNUSED), 32'hffff_ffff, 1'b0, none);
      add_row(ROW_REQ, FUNC_INIT, 0, 0, 1'b1,
              '{64'h0000_0000_7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd0});
      add_row(ROW_REQ, FUNC_PROPAGATE, 12345, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 0, -500, 1'b0, none);
      // noise sum chosen so that the innovation covariance wraps to zero
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_NOISE_HEIGHT), 32'd2147221504, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_MEAS_NOISE), 32'h7fff_ffff, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_NOISE_SPEED), 32'hffff_ffff, 1'b0, none);
      add_row(ROW_CSR, FUNC_NONE, 32'(CSR_NOISE_BIAS), 32'hffff_ffff, 1'b0, none);
      add_row(ROW_REQ, FUNC_INIT, 0, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_PROPAGATE, 0, 0, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 0, 1000, 1'b0, none);
      add_row(ROW_REQ, FUNC_UPDATE, 0, -1, 1'b0, none);

      foreach (stim_table[i]) begin
         r = stim_table[i];
         if (r.kind == ROW_CSR) csr_write(r.index, r.wdata);
         else send_request(r.func, r.accel, r.meas, r.has_exp, r.exp);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            for (int idx = CSR_INIT_HEIGHT; idx <= CSR_MEAS_NOISE; idx++)
               if (n == 0 || $urandom_range(0, 2) != 0)
                  csr_write(CSR_IDX_W'(idx), idx <= CSR_INIT_BIAS ? pick_init_value()
                                                                  : pick_noise_value());
            send_request(FUNC_INIT, $urandom, $urandom, 1'b0, none);
         end
         if (n == 300) hold_trigger = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 50) f = FUNC_PROPAGATE;
         else if (pick < 85) f = FUNC_UPDATE;
         else if (pick < 92) f = FUNC_INIT;
         else f = FUNC_NONE;
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom;
            m = $urandom;
         end else begin
            a = 32'($signed($urandom_range(0, 4000)) - 2000) - GRAVITY;
            m = 32'($signed(m_height[63:20]) + $signed($urandom_range(0, 2000)) - 1000);
         end
         send_request(f, a, m, 1'b0, none);
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("requests: %0d propagate, %0d update, %0d init, %0d unused code",
               func_count[FUNC_PROPAGATE], func_count[FUNC_UPDATE],
               func_count[FUNC_INIT], func_count[FUNC_NONE]);
      $display("zero-gain updates: %0d, mismatches: %0d, cycles: %0d",
               zero_gain_updates, mismatches, cycles);
      if (errors == 0 && expected_estimates.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
